// ===== src/otq_pkg.sv =====
// Shared types, codes and helpers for the ordered timer queue.
package otq_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAX_FIRE_DEF = 16;
    localparam int FIRE_CAP     = 16;
    localparam int QDEPTH       = 4;

    localparam logic [31:0] TMAX    = 32'hFFFF_FFFF;
    localparam logic [9:0]  REF_MAX = 10'd1023;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_KILL   = 3'd5;
    localparam logic [2:0] OP_QUERY  = 3'd6;
    localparam logic [2:0] OP_NONE   = 3'd7;

    localparam logic [3:0] K_FIRED    = 4'd0;
    localparam logic [3:0] K_ADDED    = 4'd1;
    localparam logic [3:0] K_TAKEN    = 4'd2;
    localparam logic [3:0] K_NOTFOUND = 4'd3;
    localparam logic [3:0] K_DELETED  = 4'd4;
    localparam logic [3:0] K_MARKED   = 4'd5;
    localparam logic [3:0] K_STATUS   = 4'd6;
    localparam logic [3:0] K_FULL     = 4'd7;
    localparam logic [3:0] K_CLEARED  = 4'd8;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  ref_id;
        logic [31:0] interval_ms;
        logic        keep_interval;
        logic [31:0] repeat_count;
        logic [15:0] handle;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [9:0]  ref_out;
        logic [15:0] handle_out;
        logic [31:0] wait_ms;
        logic [31:0] events_left;
        logic        last;
    } res_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TMAX : s[31:0];
    endfunction

    function automatic logic [31:0] left_of(input logic [31:0] d, input logic [31:0] now);
        return (d > now) ? (d - now) : 32'd0;
    endfunction

endpackage

// ===== src/otq_front.sv =====
// Command front: accepts items, drops unused opcodes, queues commands.
module otq_front
    import otq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);
    localparam int PW = $clog2(QDEPTH);

    cmd_t            fifo_mem [QDEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            push;
    logic            pop;

    assign in_ready = (cnt_reg != (PW+1)'(QDEPTH));
    // drop the unused opcode here so the back end never sees it
    assign push     = in_valid && in_ready && (in_cmd.op != OP_NONE);
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = fifo_mem[rd_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== src/otq_engine.sv =====
// Command engine: slot store, scans, firing and the result register.
module otq_engine
    import otq_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int MAX_FIRE = MAX_FIRE_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int LIMIT = (MAX_FIRE < FIRE_CAP) ? MAX_FIRE : FIRE_CAP;
    localparam int FW    = $clog2(FIRE_CAP + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RANK   = 4'd3;
    localparam logic [3:0] S_PLACE  = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_TSCAN  = 4'd6;
    localparam logic [3:0] S_FIRE   = 4'd7;
    localparam logic [3:0] S_FLAST  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [31:0]       dl_reg [SLOTS];
    logic [31:0]       dl_next [SLOTS];
    logic [IW-1:0]     ord_reg [SLOTS];
    logic [IW-1:0]     ord_next [SLOTS];

    logic [9:0]        ref_mem  [SLOTS];
    logic [31:0]       ivl_mem  [SLOTS];
    logic [31:0]       ev_mem   [SLOTS];
    logic              kill_mem [SLOTS];
    logic [15:0]       tag_mem  [SLOTS];

    cmd_t              cmd_reg, cmd_next;
    logic [31:0]       now_reg, now_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [9:0]        max_reg, max_next;
    logic              free_ok_reg, free_ok_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              best_ok_reg, best_ok_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [31:0]       best_dl_reg, best_dl_next;
    logic [IW-1:0]     best_ord_reg, best_ord_next;
    logic [FW-1:0]     nfire_reg, nfire_next;
    logic              pend_ok_reg, pend_ok_next;
    res_t              pend_reg, pend_next;
    res_t              res_reg, res_next;
    logic [IW-1:0]     tgt_reg, tgt_next;
    logic [31:0]       pdl_reg, pdl_next;
    logic [IW-1:0]     rank_reg, rank_next;
    logic              ret_tick_reg, ret_tick_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [IW-1:0]     sidx;
    logic              scan_end;
    logic              can_load;
    logic              unp_en;
    logic [IW-1:0]     unp_idx;
    logic [IW-1:0]     wa;
    logic              we_ref, we_ivl, we_ev, we_kill, we_tag;
    logic [9:0]        w_ref;
    logic [31:0]       w_ivl, w_ev;
    logic              w_kill;
    logic [15:0]       w_tag;
    logic [31:0]       ev_cur, rep, upd_dl, upd_iv, upd_ev;
    logic              drop;

    assign sidx      = scan_reg[IW-1:0];
    assign scan_end  = (scan_reg == CW'(SLOTS - 1));
    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    assign ev_cur = ev_mem[best_idx_reg];
    assign drop   = (ev_cur == 32'd0) || (ev_cur == 32'd1) || kill_mem[best_idx_reg];
    assign rep    = ((ev_cur == 32'd0) || (ev_cur == 32'd1)) ? 32'd0 :
                    (ev_cur == TMAX) ? TMAX : ev_cur - 32'd1;
    assign upd_dl = cmd_reg.keep_interval ? dl_reg[hit_idx_reg]
                                          : sat_add(now_reg, cmd_reg.interval_ms);
    assign upd_iv = cmd_reg.keep_interval ? ivl_mem[hit_idx_reg] : cmd_reg.interval_ms;
    assign upd_ev = (cmd_reg.repeat_count == TMAX) ? ev_mem[hit_idx_reg]
                                                   : cmd_reg.repeat_count;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        dl_next        = dl_reg;
        ord_next       = ord_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        max_next       = max_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        best_ok_next   = best_ok_reg;
        best_idx_next  = best_idx_reg;
        best_dl_next   = best_dl_reg;
        best_ord_next  = best_ord_reg;
        nfire_next     = nfire_reg;
        pend_ok_next   = pend_ok_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        tgt_next       = tgt_reg;
        pdl_next       = pdl_reg;
        rank_next      = rank_reg;
        ret_tick_next  = ret_tick_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        unp_en         = 1'b0;
        unp_idx        = hit_idx_reg;
        wa             = hit_idx_reg;
        we_ref         = 1'b0;
        we_ivl         = 1'b0;
        we_ev          = 1'b0;
        we_kill        = 1'b0;
        we_tag         = 1'b0;
        w_ref          = cmd_reg.ref_id;
        w_ivl          = cmd_reg.interval_ms;
        w_ev           = cmd_reg.repeat_count;
        w_kill         = 1'b0;
        w_tag          = cmd_reg.handle;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    cmd_next     = q_cmd;
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    max_next     = '0;
                    free_ok_next = 1'b0;
                    best_ok_next = 1'b0;
                    nfire_next   = '0;
                    pend_ok_next = 1'b0;
                    if (q_cmd.op == OP_TICK)
                    begin
                        now_next   = (now_reg == TMAX) ? TMAX : now_reg + 32'd1;
                        state_next = S_TSCAN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // one slot a cycle: look for the ref, the largest ref, a free slot
                if (valid_reg[sidx])
                begin
                    if (!hit_reg && ref_mem[sidx] == cmd_reg.ref_id)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = sidx;
                    end
                    if (ref_mem[sidx] > max_reg)
                    begin
                        max_next = ref_mem[sidx];
                    end
                end
                else if (!free_ok_reg)
                begin
                    free_ok_next  = 1'b1;
                    free_idx_next = sidx;
                end
                scan_next = scan_reg + CW'(1);
                if (scan_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_next            = '0;
                res_next.ref_out    = cmd_reg.ref_id;
                res_next.last       = 1'b1;
                ret_tick_next       = 1'b0;
                scan_next           = '0;
                rank_next           = '0;
                state_next          = S_EMIT;
                unique case (cmd_reg.op)
                    OP_ADD:
                    begin
                        if (cmd_reg.ref_id == '0 && max_reg == REF_MAX)
                        begin
                            res_next.kind    = K_FULL;
                            res_next.ref_out = '0;
                        end
                        else if (cmd_reg.ref_id != '0 && hit_reg)
                        begin
                            res_next.kind = K_TAKEN;
                        end
                        else if (!free_ok_reg)
                        begin
                            res_next.kind = K_FULL;
                        end
                        else
                        begin
                            w_ref   = (cmd_reg.ref_id == '0) ? max_reg + 10'd1 : cmd_reg.ref_id;
                            wa      = free_idx_reg;
                            we_ref  = 1'b1;
                            we_ivl  = 1'b1;
                            we_ev   = 1'b1;
                            we_kill = 1'b1;
                            we_tag  = 1'b1;
                            tgt_next             = free_idx_reg;
                            pdl_next             = sat_add(now_reg, cmd_reg.interval_ms);
                            res_next.kind        = K_ADDED;
                            res_next.ref_out     = w_ref;
                            res_next.handle_out  = cmd_reg.handle;
                            res_next.events_left = cmd_reg.repeat_count;
                            state_next           = S_RANK;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.kind = K_NOTFOUND;
                        end
                        else
                        begin
                            unp_en  = 1'b1;
                            w_ivl   = upd_iv;
                            w_ev    = upd_ev;
                            we_ivl  = 1'b1;
                            we_ev   = 1'b1;
                            we_kill = 1'b1;
                            we_tag  = 1'b1;
                            tgt_next             = hit_idx_reg;
                            pdl_next             = upd_dl;
                            res_next.kind        = K_ADDED;
                            res_next.handle_out  = cmd_reg.handle;
                            res_next.events_left = upd_ev;
                            state_next           = S_RANK;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.kind = K_NOTFOUND;
                        end
                        else
                        begin
                            unp_en        = 1'b1;
                            res_next.kind = K_DELETED;
                        end
                    end
                    OP_CLEAR:
                    begin
                        valid_next       = '0;
                        res_next.kind    = K_CLEARED;
                        res_next.ref_out = '0;
                    end
                    OP_KILL:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.kind = K_NOTFOUND;
                        end
                        else
                        begin
                            w_kill        = 1'b1;
                            we_kill       = 1'b1;
                            res_next.kind = K_MARKED;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!hit_reg)
                        begin
                            res_next.kind = K_NOTFOUND;
                        end
                        else
                        begin
                            res_next.kind        = K_STATUS;
                            res_next.handle_out  = tag_mem[hit_idx_reg];
                            res_next.wait_ms     = left_of(dl_reg[hit_idx_reg], now_reg);
                            res_next.events_left = ev_mem[hit_idx_reg];
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RANK:
            begin
                // the target is already invalid, so count peers on the new deadline
                if (valid_reg[sidx] && dl_reg[sidx] == pdl_reg)
                begin
                    rank_next = rank_reg + IW'(1);
                end
                scan_next = scan_reg + CW'(1);
                if (scan_end)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                dl_next[tgt_reg]    = pdl_reg;
                ord_next[tgt_reg]   = rank_reg;
                valid_next[tgt_reg] = 1'b1;
                scan_next           = '0;
                best_ok_next        = 1'b0;
                if (ret_tick_reg)
                begin
                    state_next = (nfire_reg == FW'(LIMIT)) ? S_FLAST : S_TSCAN;
                end
                else
                begin
                    res_next.wait_ms = left_of(pdl_reg, now_reg);
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            S_TSCAN:
            begin
                // pick the earliest due slot, oldest first among equal deadlines
                if (valid_reg[sidx] && dl_reg[sidx] < now_reg)
                begin
                    if (!best_ok_reg || dl_reg[sidx] < best_dl_reg ||
                        (dl_reg[sidx] == best_dl_reg && ord_reg[sidx] < best_ord_reg))
                    begin
                        best_ok_next  = 1'b1;
                        best_idx_next = sidx;
                        best_dl_next  = dl_reg[sidx];
                        best_ord_next = ord_reg[sidx];
                    end
                end
                scan_next = scan_reg + CW'(1);
                if (scan_end)
                begin
                    if (best_ok_next)
                    begin
                        state_next = S_FIRE;
                    end
                    else
                    begin
                        state_next = pend_ok_reg ? S_FLAST : S_IDLE;
                    end
                end
            end
            S_FIRE:
            begin
                // hold until the previous fire can go out
                if (!pend_ok_reg || can_load)
                begin
                    if (pend_ok_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                    end
                    pend_ok_next         = 1'b1;
                    pend_next            = '0;
                    pend_next.kind       = K_FIRED;
                    pend_next.ref_out    = ref_mem[best_idx_reg];
                    pend_next.handle_out = tag_mem[best_idx_reg];
                    pend_next.events_left = rep;
                    nfire_next           = nfire_reg + FW'(1);
                    unp_en               = 1'b1;
                    unp_idx              = best_idx_reg;
                    scan_next            = '0;
                    best_ok_next         = 1'b0;
                    if (!drop)
                    begin
                        wa            = best_idx_reg;
                        w_ev          = rep;
                        we_ev         = 1'b1;
                        tgt_next      = best_idx_reg;
                        pdl_next      = sat_add(dl_reg[best_idx_reg], ivl_mem[best_idx_reg]);
                        rank_next     = '0;
                        ret_tick_next = 1'b1;
                        state_next    = S_RANK;
                    end
                    else
                    begin
                        state_next = (nfire_next == FW'(LIMIT)) ? S_FLAST : S_TSCAN;
                    end
                end
            end
            S_FLAST:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_next.last  = 1'b1;
                    pend_ok_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // remove a slot and close the gap in its deadline's rank order
        if (unp_en)
        begin
            valid_next[unp_idx] = 1'b0;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (valid_reg[j] && dl_reg[j] == dl_reg[unp_idx] &&
                    ord_reg[j] > ord_reg[unp_idx])
                begin
                    ord_next[j] = ord_reg[j] - IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_ref)  ref_mem[wa]  <= w_ref;
        if (we_ivl)  ivl_mem[wa]  <= w_ivl;
        if (we_ev)   ev_mem[wa]   <= w_ev;
        if (we_kill) kill_mem[wa] <= w_kill;
        if (we_tag)  tag_mem[wa]  <= w_tag;
        dl_reg       <= dl_next;
        ord_reg      <= ord_next;
        cmd_reg      <= cmd_next;
        hit_idx_reg  <= hit_idx_next;
        max_reg      <= max_next;
        free_idx_reg <= free_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_ord_reg <= best_ord_next;
        pend_reg     <= pend_next;
        res_reg      <= res_next;
        tgt_reg      <= tgt_next;
        pdl_reg      <= pdl_next;
        rank_reg     <= rank_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            now_reg       <= '0;
            scan_reg      <= '0;
            hit_reg       <= 1'b0;
            free_ok_reg   <= 1'b0;
            best_ok_reg   <= 1'b0;
            nfire_reg     <= '0;
            pend_ok_reg   <= 1'b0;
            ret_tick_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            now_reg       <= now_next;
            scan_reg      <= scan_next;
            hit_reg       <= hit_next;
            free_ok_reg   <= free_ok_next;
            best_ok_reg   <= best_ok_next;
            nfire_reg     <= nfire_next;
            pend_ok_reg   <= pend_ok_next;
            ret_tick_reg  <= ret_tick_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== src/ordered_timer_queue_core.sv =====
// Top level of the ordered timer queue: stream ports, front queue and engine.
//
//  channel  | direction | handshake           | content
//  ---------+-----------+---------------------+-------------------------------
//  s_*      | in        | s_tvalid / s_tready | one command or 1 ms tick item
//  m_*      | out       | m_tvalid / m_tready | result items, m_tlast on final
//
// Flow: an accepted item is registered in the front queue, then a command
// holds the engine through pop, slot scan, decide and emit; add and update
// rank the new deadline in a second scan and a place step before the emit.
// A tick pops and scans the slots; each fire adds a fire step and a scan, each
// rescheduled timer a rank scan and a place step; the final fire goes out after
// the last scan. Reset clears all timers and the ms clock at once; a low m_tready
// holds the engine and a four-item command queue keeps taking items meanwhile.
module ordered_timer_queue_core
    import otq_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int MAX_FIRE = MAX_FIRE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ref_id[9:0], interval_ms[41:10], keep_interval[42], repeat_count[74:43],
    // handle[90:75], zero fill above
    input  logic [95:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ref_out[9:0], handle_out[25:10], wait_ms[57:26], events_left[89:58],
    // zero fill above
    output logic [95:0] m_tdata,
    // kind[3:0]
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);
    cmd_t in_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;
    res_t res;

    // unpack the incoming item
    always_comb
    begin
        in_cmd.op            = s_tuser;
        in_cmd.ref_id        = s_tdata[9:0];
        in_cmd.interval_ms   = s_tdata[41:10];
        in_cmd.keep_interval = s_tdata[42];
        in_cmd.repeat_count  = s_tdata[74:43];
        in_cmd.handle        = s_tdata[90:75];
    end

    otq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    otq_engine #(
        .SLOTS    (SLOTS),
        .MAX_FIRE (MAX_FIRE)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the result item
    assign m_tdata = {6'd0, res.events_left, res.wait_ms, res.handle_out, res.ref_out};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule
